// File: hdl/pobf_pkg.sv
package pobf_pkg;

   localparam int POS_W = 32;            // position and offset width
   localparam int QUAT_W = 16;           // quaternion component width
   localparam int NORM_W = 33;           // squared norm, unsigned, up to 2^32
   localparam int QUO_W = 33;            // quotient bits produced by the divider
   localparam int DIVD_W = 65;           // rounded dividend width
   localparam int REM_W = DIVD_W - QUO_W; // top dividend bits, below the norm

   typedef struct packed {
      logic [2:0][POS_W-1:0] pos;
      logic [2:0][POS_W-1:0] offset;
   } side_type;

   typedef struct packed {
      side_type                side;
      logic [NORM_W-1:0]       norm;
      logic                    zero;
      logic [2:0]              neg;
      logic [2:0][NORM_W-1:0]  rem;
      logic [2:0][QUO_W-1:0]   low;
      logic [2:0][QUO_W-1:0]   quo;
   } div_type;

endpackage

// File: hdl/pobf_div.sv
// Restoring divider, one quotient bit per stage, three lanes sharing one divisor.
module pobf_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              valid_in,
   input  pobf_pkg::div_type d_in,
   output logic              valid_out,
   output pobf_pkg::div_type d_out
);

   pobf_pkg::div_type       st_ff [pobf_pkg::QUO_W];
   pobf_pkg::div_type       st_in [pobf_pkg::QUO_W];
   logic [pobf_pkg::QUO_W-1:0] vld_ff;

   function automatic pobf_pkg::div_type step(input pobf_pkg::div_type d);
      pobf_pkg::div_type        r;
      logic [pobf_pkg::NORM_W:0] part;
      logic [pobf_pkg::NORM_W:0] diff;
      r = d;
      for (int i = 0; i < 3; i++) begin
         part = {d.rem[i], d.low[i][pobf_pkg::QUO_W-1]};
         diff = part - {1'b0, d.norm};
         r.low[i] = {d.low[i][pobf_pkg::QUO_W-2:0], 1'b0};
         if (part >= {1'b0, d.norm}) begin
            r.rem[i] = diff[pobf_pkg::NORM_W-1:0];
            r.quo[i] = {d.quo[i][pobf_pkg::QUO_W-2:0], 1'b1};
         end else begin
            r.rem[i] = part[pobf_pkg::NORM_W-1:0];
            r.quo[i] = {d.quo[i][pobf_pkg::QUO_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   always_comb begin
      st_in[0] = step(d_in);
      for (int k = 1; k < pobf_pkg::QUO_W; k++) begin
         st_in[k] = step(st_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[pobf_pkg::QUO_W-2:0], valid_in};
      end
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign valid_out = vld_ff[pobf_pkg::QUO_W-1];
   assign d_out = st_ff[pobf_pkg::QUO_W-1];

endmodule

// File: hdl/pose_offset_in_body_frame.sv
// Pipeline from req item accepted to rsp item valid: 8 front stages,
// 33 divider stages, 1 output stage.
// Throughput: one item per cycle; the whole pipeline holds while rsp is stalled.
// Reset (synchronous, active high) clears all valid bits; payload is not reset.
module pose_offset_in_body_frame (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, offset_x, offset_y, offset_z
   input  logic [255:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_x, new_y, new_z
   output logic [95:0]  rsp_tdata,
   // saturated
   output logic         rsp_tuser
);

   localparam int PW = pobf_pkg::POS_W;
   localparam int NW = pobf_pkg::NORM_W;

   logic en;
   logic [7:0] fv_ff;
   logic rsp_valid_ff;

   // global advance: the output register is free or being emptied
   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (en) begin
         fv_ff <= {fv_ff[6:0], req_tvalid};
      end
   end

   // stage 1: capture item
   pobf_pkg::side_type s1_side_ff;
   logic [3:0][15:0]   s1_q_ff;   // x, y, z, w
   always_ff @(posedge clock) begin
      if (en) begin
         s1_side_ff.pos    <= req_tdata[95:0];
         s1_q_ff           <= req_tdata[159:96];
         s1_side_ff.offset <= req_tdata[255:160];
      end
   end

   // stage 2: all quaternion products
   logic signed [15:0] qx, qy, qz, qw;
   assign qx = $signed(s1_q_ff[0]);
   assign qy = $signed(s1_q_ff[1]);
   assign qz = $signed(s1_q_ff[2]);
   assign qw = $signed(s1_q_ff[3]);

   pobf_pkg::side_type s2_side_ff;
   logic signed [31:0] xx_ff, yy_ff, zz_ff, ww_ff, xy_ff, zw_ff, xz_ff, yw_ff, yz_ff, xw_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s2_side_ff <= s1_side_ff;
         xx_ff <= qx * qx;
         yy_ff <= qy * qy;
         zz_ff <= qz * qz;
         ww_ff <= qw * qw;
         xy_ff <= qx * qy;
         zw_ff <= qz * qw;
         xz_ff <= qx * qz;
         yw_ff <= qy * qw;
         yz_ff <= qy * qz;
         xw_ff <= qx * qw;
      end
   end

   // stage 3: norm and scaled rotation matrix M = n*R, row-major
   logic signed [34:0] n35, m_in [9];
   assign n35 = 35'(xx_ff) + 35'(yy_ff) + 35'(zz_ff) + 35'(ww_ff);
   always_comb begin
      m_in[0] = n35 - 35'(2) * (35'(yy_ff) + 35'(zz_ff));
      m_in[1] = 35'(2) * (35'(xy_ff) - 35'(zw_ff));
      m_in[2] = 35'(2) * (35'(xz_ff) + 35'(yw_ff));
      m_in[3] = 35'(2) * (35'(xy_ff) + 35'(zw_ff));
      m_in[4] = n35 - 35'(2) * (35'(xx_ff) + 35'(zz_ff));
      m_in[5] = 35'(2) * (35'(yz_ff) - 35'(xw_ff));
      m_in[6] = 35'(2) * (35'(xz_ff) - 35'(yw_ff));
      m_in[7] = 35'(2) * (35'(yz_ff) + 35'(xw_ff));
      m_in[8] = n35 - 35'(2) * (35'(xx_ff) + 35'(yy_ff));
   end

   pobf_pkg::side_type s3_side_ff;
   logic [NW-1:0]      s3_n_ff;
   logic               s3_zero_ff;
   logic signed [34:0] m_ff [9];
   always_ff @(posedge clock) begin
      if (en) begin
         s3_side_ff <= s2_side_ff;
         s3_n_ff    <= n35[NW-1:0];
         s3_zero_ff <= (n35 == '0);
         m_ff       <= m_in;
      end
   end

   // stage 4: M*t split into 18 x 32 partial products
   logic signed [49:0] ph_in [9], pl_in [9];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            ph_in[3*i+j] = $signed(m_ff[3*i+j][34:17]) * $signed(s3_side_ff.offset[j]);
            pl_in[3*i+j] = $signed({1'b0, m_ff[3*i+j][16:0]}) *
                           $signed(s3_side_ff.offset[j]);
         end
      end
   end

   pobf_pkg::side_type s4_side_ff;
   logic [NW-1:0]      s4_n_ff;
   logic               s4_zero_ff;
   logic signed [49:0] ph_ff [9], pl_ff [9];
   always_ff @(posedge clock) begin
      if (en) begin
         s4_side_ff <= s3_side_ff;
         s4_n_ff    <= s3_n_ff;
         s4_zero_ff <= s3_zero_ff;
         ph_ff      <= ph_in;
         pl_ff      <= pl_in;
      end
   end

   // stage 5: recombine partial products
   logic signed [67:0] tm_in [9];
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         tm_in[k] = (68'(ph_ff[k]) <<< 17) + 68'(pl_ff[k]);
      end
   end

   pobf_pkg::side_type s5_side_ff;
   logic [NW-1:0]      s5_n_ff;
   logic               s5_zero_ff;
   logic signed [67:0] tm_ff [9];
   always_ff @(posedge clock) begin
      if (en) begin
         s5_side_ff <= s4_side_ff;
         s5_n_ff    <= s4_n_ff;
         s5_zero_ff <= s4_zero_ff;
         tm_ff      <= tm_in;
      end
   end

   // stage 6: row sums
   pobf_pkg::side_type s6_side_ff;
   logic [NW-1:0]      s6_n_ff;
   logic               s6_zero_ff;
   logic signed [67:0] acc_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         s6_side_ff <= s5_side_ff;
         s6_n_ff    <= s5_n_ff;
         s6_zero_ff <= s5_zero_ff;
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= tm_ff[3*i] + tm_ff[3*i+1] + tm_ff[3*i+2];
         end
      end
   end

   // stage 7: sign and magnitude (magnitude stays below 2^64)
   logic signed [67:0] acc_neg [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_neg[i] = -acc_ff[i];
      end
   end

   pobf_pkg::side_type s7_side_ff;
   logic [NW-1:0]      s7_n_ff;
   logic               s7_zero_ff;
   logic [2:0]         s7_neg_ff;
   logic [63:0]        mag_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         s7_side_ff <= s6_side_ff;
         s7_n_ff    <= s6_n_ff;
         s7_zero_ff <= s6_zero_ff;
         for (int i = 0; i < 3; i++) begin
            s7_neg_ff[i] <= acc_ff[i][67];
            mag_ff[i]    <= acc_ff[i][67] ? acc_neg[i][63:0] : acc_ff[i][63:0];
         end
      end
   end

   // stage 8: add half the divisor for round half away from zero
   pobf_pkg::side_type s8_side_ff;
   logic [NW-1:0]      s8_n_ff;
   logic               s8_zero_ff;
   logic [2:0]         s8_neg_ff;
   logic [pobf_pkg::DIVD_W-1:0] dd_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         s8_side_ff <= s7_side_ff;
         s8_n_ff    <= s7_n_ff;
         s8_zero_ff <= s7_zero_ff;
         s8_neg_ff  <= s7_neg_ff;
         for (int i = 0; i < 3; i++) begin
            dd_ff[i] <= {1'b0, mag_ff[i]} + pobf_pkg::DIVD_W'(s7_n_ff >> 1);
         end
      end
   end

   // divider: dividend top bits start the remainder, they are below the norm
   pobf_pkg::div_type d_in, d_out;
   logic              div_valid;
   always_comb begin
      d_in.side = s8_side_ff;
      d_in.norm = s8_n_ff;
      d_in.zero = s8_zero_ff;
      d_in.neg  = s8_neg_ff;
      for (int i = 0; i < 3; i++) begin
         d_in.rem[i] = NW'(dd_ff[i][pobf_pkg::DIVD_W-1:pobf_pkg::QUO_W]);
         d_in.low[i] = dd_ff[i][pobf_pkg::QUO_W-1:0];
         d_in.quo[i] = '0;
      end
   end

   pobf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (fv_ff[7]),
      .d_in      (d_in),
      .valid_out (div_valid),
      .d_out     (d_out)
   );

   // output stage: sign, zero-norm identity, add position, saturate
   logic signed [34:0] rot [3], sum [3];
   logic [2:0][PW-1:0] new_in;
   logic [2:0]         sat_in;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (d_out.zero) begin
            rot[i] = 35'($signed(d_out.side.offset[i]));
         end else if (d_out.neg[i]) begin
            rot[i] = -$signed({2'b00, d_out.quo[i]});
         end else begin
            rot[i] = $signed({2'b00, d_out.quo[i]});
         end
         sum[i] = 35'($signed(d_out.side.pos[i])) + rot[i];
         if (sum[i] > 35'sh0_7FFF_FFFF) begin
            new_in[i] = 32'h7FFF_FFFF;
            sat_in[i] = 1'b1;
         end else if (sum[i] < -35'sh0_8000_0000) begin
            new_in[i] = 32'h8000_0000;
            sat_in[i] = 1'b1;
         end else begin
            new_in[i] = sum[i][PW-1:0];
            sat_in[i] = 1'b0;
         end
      end
   end

   logic [95:0] rsp_data_ff;
   logic        rsp_sat_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid;
      end
      if (en) begin
         rsp_data_ff <= new_in;
         rsp_sat_ff  <= |sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

// File: verif/tb_pose_offset_in_body_frame.sv
`timescale 1ns / 100ps

module tb_pose_offset_in_body_frame;

   // one pending pose item; hold makes the sender wait for the pipe to drain first
   typedef struct {
      logic [255:0] data;
      bit           hold;
   } pose_item_type;

   // one moved-position result
   typedef struct {
      logic [pobf_pkg::POS_W-1:0] x;
      logic [pobf_pkg::POS_W-1:0] y;
      logic [pobf_pkg::POS_W-1:0] z;
      logic                       sat;
   } moved_pos_type;

   localparam int WATCHDOG_LIMIT = 4000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, offset_x, offset_y, offset_z
   logic [255:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // new_x, new_y, new_z
   logic [95:0]  rsp_tdata;
   // saturated
   logic         rsp_tuser;

   pose_item_type pending_poses[$];
   moved_pos_type moved_pos_q[$];
   int            fail_count = 0;
   int            send_gap = 0;
   int            recv_stall = 0;
   int            quiet_cycles = 0;
   bit            calm;

   pose_offset_in_body_frame u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // no idling once the tail of the stimulus is reached
   assign calm = pending_poses.size() < 40;

   // p + round(M*t / n), M = n*R(q), exact in 128 bits, then clipped to 32 bits
   function automatic moved_pos_type rotate_offset(input logic [255:0] d);
      logic signed [127:0] p[3];
      logic signed [127:0] t[3];
      logic signed [127:0] m[9];
      logic signed [127:0] qx, qy, qz, qw, xx, yy, zz, ww, n;
      logic signed [127:0] acc, mag, quo, s;
      logic [pobf_pkg::POS_W-1:0] v[3];
      moved_pos_type       res;
      res.sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         p[i] = $signed(d[i*32 +: 32]);
         t[i] = $signed(d[160 + i*32 +: 32]);
      end
      qx = $signed(d[111:96]);
      qy = $signed(d[127:112]);
      qz = $signed(d[143:128]);
      qw = $signed(d[159:144]);
      xx = qx * qx;
      yy = qy * qy;
      zz = qz * qz;
      ww = qw * qw;
      n = xx + yy + zz + ww;
      m[0] = n - 2 * (yy + zz);
      m[1] = 2 * (qx * qy - qz * qw);
      m[2] = 2 * (qx * qz + qy * qw);
      m[3] = 2 * (qx * qy + qz * qw);
      m[4] = n - 2 * (xx + zz);
      m[5] = 2 * (qy * qz - qx * qw);
      m[6] = 2 * (qx * qz - qy * qw);
      m[7] = 2 * (qy * qz + qx * qw);
      m[8] = n - 2 * (xx + yy);
      for (int i = 0; i < 3; i++) begin
         if (n == 0) begin
            // zero quaternion: identity rotation
            quo = t[i];
         end else begin
            acc = m[3*i] * t[0] + m[3*i+1] * t[1] + m[3*i+2] * t[2];
            mag = (acc < 0) ? -acc : acc;
            quo = (mag + (n >>> 1)) / n;   // nearest, ties away from zero
            if (acc < 0) quo = -quo;
         end
         s = p[i] + quo;
         if (s > 128'sd2147483647) begin
            s = 128'sd2147483647;
            res.sat = 1'b1;
         end else if (s < -128'sd2147483648) begin
            s = -128'sd2147483648;
            res.sat = 1'b1;
         end
         v[i] = s[31:0];
      end
      res.x = v[0];
      res.y = v[1];
      res.z = v[2];
      return res;
   endfunction

   task automatic queue_pose(input logic [31:0] px, py, pz, input logic [15:0] qx, qy, qz, qw,
                             input logic [31:0] ox, oy, oz, input bit hold = 0);
      pose_item_type it;
      it.data = {oz, oy, ox, qw, qz, qy, qx, pz, py, px};
      it.hold = hold;
      pending_poses.push_back(it);
   endtask

   function automatic logic [15:0] rand_quat(input int kind);
      if (kind == 0) return 16'($urandom());
      return 16'($urandom_range(0, 32767) - 16384);  // roughly unit range
   endfunction

   function automatic logic [31:0] rand_coord(input int kind);
      if (kind == 0) return $urandom();
      return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
   endfunction

   // sender: present the next item once the previous one is taken
   always @(posedge clock) begin
      pose_item_type it;
      bit            busy;
      bit            v;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            moved_pos_q.push_back(rotate_offset(req_tdata));
            busy = 1'b0;
         end
         if (!busy) begin
            v = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_poses.size() > 0 &&
                         (!pending_poses[0].hold || moved_pos_q.size() == 0)) begin
               it = pending_poses.pop_front();
               v = 1'b1;
               req_tdata <= it.data;
               if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 18);
            end
            req_tvalid <= v;
         end
      end
   end

   // receiver: random back-pressure, compare every item with the oldest prediction
   always @(posedge clock) begin
      moved_pos_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (moved_pos_q.size() == 0) begin
               $error("unexpected result item %h", rsp_tdata);
               fail_count++;
            end else begin
               want = moved_pos_q.pop_front();
               if (rsp_tdata[31:0] !== want.x) begin
                  $error("new_x: expected %h, got %h", want.x, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[63:32] !== want.y) begin
                  $error("new_y: expected %h, got %h", want.y, rsp_tdata[63:32]);
                  fail_count++;
               end
               if (rsp_tdata[95:64] !== want.z) begin
                  $error("new_z: expected %h, got %h", want.z, rsp_tdata[95:64]);
                  fail_count++;
               end
               if (rsp_tuser !== want.sat) begin
                  $error("saturated: expected %b, got %b", want.sat, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) recv_stall = $urandom_range(1, 18);
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int kq, kp, ko;
      reset = 1'b1;

      // directed: identity, zero quaternion, quarter turns, extremes, saturation
      queue_pose(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h0000, 16'h0000,
                 16'h0000, 16'h4000, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_0001);
      queue_pose(32'h1234_5678, 32'hFEDC_BA98, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                 32'h0000_4000, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'h0, 16'h0, 16'h0,
                 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000);
      queue_pose(32'h0, 32'h0, 32'h0, 16'h2D41, 16'h0, 16'h0, 16'h2D41,
                 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      queue_pose(32'h0, 32'h0, 32'h0, 16'h0, 16'h2D41, 16'h0, 16'h2D41,
                 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      queue_pose(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'hD2BF, 16'h2D41,
                 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      queue_pose(32'h0, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 16'h0,
                 32'h0000_0003, 32'h0000_0005, 32'hFFFF_FFF9);
      queue_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 16'h8000,
                 16'h8000, 16'h8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h7FFF, 16'h7FFF,
                 16'h7FFF, 16'h7FFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      queue_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h7FFF, 16'h8000, 16'h0001,
                 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_pose(32'h0, 32'h0, 32'h0, 16'h0001, 16'h0, 16'h0, 16'h0,
                 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
      queue_pose(32'h0, 32'h0, 32'h0, 16'h0001, 16'h0001, 16'h0, 16'h0,
                 32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0003);
      queue_pose(32'hFFFF_FFFF, 32'h0, 32'h1, 16'h0, 16'h0, 16'h0, 16'h2000,
                 32'h0000_0005, 32'hFFFF_FFFB, 32'h0);
      queue_pose(32'h7FFF_0000, 32'h8001_0000, 32'h0, 16'h1000, 16'h2000, 16'h3000,
                 16'h0800, 32'h0100_0000, 32'hFF00_0000, 32'h0080_0000);

      // random: mostly near-unit quaternions and moderate coordinates, some raw bits
      for (int i = 0; i < 450; i++) begin
         kq = ($urandom_range(0, 3) == 0) ? 0 : 1;
         kp = ($urandom_range(0, 2) == 0) ? 0 : 1;
         ko = ($urandom_range(0, 2) == 0) ? 0 : 1;
         queue_pose(rand_coord(kp), rand_coord(kp), rand_coord(kp),
                    rand_quat(kq), rand_quat(kq), rand_quat(kq), rand_quat(kq),
                    rand_coord(ko), rand_coord(ko), rand_coord(ko),
                    (i == 0 || i == 200));
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (pending_poses.size() == 0 && !req_tvalid && moved_pos_q.size() == 0);
      repeat (60) @(posedge clock);
      if (fail_count == 0 && moved_pos_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
